FILE: rtl/boosted_velocity_histogram_defines.svh
// assertion macros for the boosted velocity histogram
// used by the top level only, expects clk and rst_n in scope
`ifndef BOOSTED_VELOCITY_HISTOGRAM_DEFINES_SVH
`define BOOSTED_VELOCITY_HISTOGRAM_DEFINES_SVH

// same-cycle implication
`define BVH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BVH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bvh_pkg.sv
// shared types, codes and helpers for the boosted velocity histogram
// no dependencies
package bvh_pkg;

    localparam int BIN_SPAN_DEF = 399;

    localparam logic [1:0] FUNC_CLR  = 2'd0;
    localparam logic [1:0] FUNC_ADD  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic [2:0] ST_COUNTED  = 3'd0;
    localparam logic [2:0] ST_FILTERED = 3'd1;
    localparam logic [2:0] ST_OOR      = 3'd2;
    localparam logic [2:0] ST_READ     = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    localparam logic [2:0] REG_BETA      = 3'd0;
    localparam logic [2:0] REG_INV_GAMMA = 3'd1;
    localparam logic [2:0] REG_SPECIES   = 3'd2;
    localparam logic [2:0] REG_CELL_LO   = 3'd3;
    localparam logic [2:0] REG_CELL_HI   = 3'd4;

    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_ACCEPT    = 5'd1;
    localparam logic [4:0] OP_CLR       = 5'd2;
    localparam logic [4:0] OP_RDOUT     = 5'd3;
    localparam logic [4:0] OP_FILT      = 5'd4;
    localparam logic [4:0] OP_MUL_VX0   = 5'd5;
    localparam logic [4:0] OP_MUL_VY0   = 5'd6;
    localparam logic [4:0] OP_MUL_VZ0   = 5'd7;
    localparam logic [4:0] OP_MUL_D     = 5'd8;
    localparam logic [4:0] OP_MUL_NX    = 5'd9;
    localparam logic [4:0] OP_MUL_NZ    = 5'd10;
    localparam logic [4:0] OP_NUM_Z     = 5'd11;
    localparam logic [4:0] OP_DIV_INIT  = 5'd12;
    localparam logic [4:0] OP_DIV_STEP  = 5'd13;
    localparam logic [4:0] OP_DIV_FIN   = 5'd14;
    localparam logic [4:0] OP_SQ_X      = 5'd15;
    localparam logic [4:0] OP_SQ_Y      = 5'd16;
    localparam logic [4:0] OP_SQ_Z      = 5'd17;
    localparam logic [4:0] OP_SQ_ACC    = 5'd18;
    localparam logic [4:0] OP_SQRT_STEP = 5'd19;
    localparam logic [4:0] OP_BIN       = 5'd20;
    localparam logic [4:0] OP_RMW_RD    = 5'd21;
    localparam logic [4:0] OP_RMW_WR    = 5'd22;

    typedef struct packed {
        logic [4:0] op;
        logic       res_en;
    } bvh_cmd_t;

    typedef struct packed {
        logic keep;
        logic clr_last;
        logic it_last;
    } bvh_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/bvh_ctrl.sv
// sequencing state machine for the boosted velocity histogram
// depends on bvh_pkg
module bvh_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        func,
    input  bvh_pkg::bvh_stat_t stat,
    output bvh_pkg::bvh_cmd_t  cmd,
    output logic              busy,
    output logic              done
);

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_CLR   = 5'd2;
    localparam logic [4:0] S_RDOUT = 5'd3;
    localparam logic [4:0] S_FILT  = 5'd4;
    localparam logic [4:0] S_M1    = 5'd5;
    localparam logic [4:0] S_M2    = 5'd6;
    localparam logic [4:0] S_M3    = 5'd7;
    localparam logic [4:0] S_M4    = 5'd8;
    localparam logic [4:0] S_M5    = 5'd9;
    localparam logic [4:0] S_M6    = 5'd10;
    localparam logic [4:0] S_NZ    = 5'd11;
    localparam logic [4:0] S_DINIT = 5'd12;
    localparam logic [4:0] S_DIV   = 5'd13;
    localparam logic [4:0] S_DFIN  = 5'd14;
    localparam logic [4:0] S_SQX   = 5'd15;
    localparam logic [4:0] S_SQY   = 5'd16;
    localparam logic [4:0] S_SQZ   = 5'd17;
    localparam logic [4:0] S_SQA   = 5'd18;
    localparam logic [4:0] S_SQRT  = 5'd19;
    localparam logic [4:0] S_BIN   = 5'd20;
    localparam logic [4:0] S_RMWR  = 5'd21;
    localparam logic [4:0] S_RMWW  = 5'd22;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bvh_pkg::OP_NONE;
        cmd.res_en = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op = bvh_pkg::OP_CLR;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = bvh_pkg::OP_ACCEPT;
                    if (func == bvh_pkg::FUNC_CLR)
                        state_next = S_CLR;
                    else if (func == bvh_pkg::FUNC_READ)
                        state_next = S_RDOUT;
                    else if (stat.keep)
                        state_next = S_M1;
                    else
                        state_next = S_FILT;
                end
            end
            S_CLR:
            begin
                cmd.op = bvh_pkg::OP_CLR;
                if (stat.clr_last)
                begin
                    cmd.res_en = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RDOUT:
            begin
                cmd.op     = bvh_pkg::OP_RDOUT;
                cmd.res_en = 1'b1;
                state_next = S_IDLE;
            end
            S_FILT:
            begin
                cmd.op     = bvh_pkg::OP_FILT;
                cmd.res_en = 1'b1;
                state_next = S_IDLE;
            end
            S_M1:
            begin
                cmd.op     = bvh_pkg::OP_MUL_VX0;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd.op     = bvh_pkg::OP_MUL_VY0;
                state_next = S_M3;
            end
            S_M3:
            begin
                cmd.op     = bvh_pkg::OP_MUL_VZ0;
                state_next = S_M4;
            end
            S_M4:
            begin
                cmd.op     = bvh_pkg::OP_MUL_D;
                state_next = S_M5;
            end
            S_M5:
            begin
                cmd.op     = bvh_pkg::OP_MUL_NX;
                state_next = S_M6;
            end
            S_M6:
            begin
                cmd.op     = bvh_pkg::OP_MUL_NZ;
                state_next = S_NZ;
            end
            S_NZ:
            begin
                cmd.op     = bvh_pkg::OP_NUM_Z;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.op     = bvh_pkg::OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = bvh_pkg::OP_DIV_STEP;
                if (stat.it_last)
                    state_next = S_DFIN;
            end
            S_DFIN:
            begin
                cmd.op     = bvh_pkg::OP_DIV_FIN;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                cmd.op     = bvh_pkg::OP_SQ_X;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.op     = bvh_pkg::OP_SQ_Y;
                state_next = S_SQZ;
            end
            S_SQZ:
            begin
                cmd.op     = bvh_pkg::OP_SQ_Z;
                state_next = S_SQA;
            end
            S_SQA:
            begin
                cmd.op     = bvh_pkg::OP_SQ_ACC;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = bvh_pkg::OP_SQRT_STEP;
                if (stat.it_last)
                    state_next = S_BIN;
            end
            S_BIN:
            begin
                cmd.op     = bvh_pkg::OP_BIN;
                state_next = S_RMWR;
            end
            S_RMWR:
            begin
                cmd.op     = bvh_pkg::OP_RMW_RD;
                state_next = S_RMWW;
            end
            S_RMWW:
            begin
                cmd.op     = bvh_pkg::OP_RMW_WR;
                cmd.res_en = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.res_en;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

FILE: rtl/bvh_datapath.sv
// arithmetic, configuration registers and bin memories of the histogram
// depends on bvh_pkg, driven by bvh_ctrl
module bvh_datapath
#(
    parameter int BIN_SPAN = bvh_pkg::BIN_SPAN_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bvh_pkg::bvh_cmd_t   cmd,
    output bvh_pkg::bvh_stat_t  stat,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [1:0]          func,
    input  logic signed [31:0]  mom_x,
    input  logic signed [31:0]  mom_y,
    input  logic signed [31:0]  mom_z,
    input  logic [30:0]         inv_lorentz,
    input  logic [15:0]         cell_number,
    input  logic [3:0]          species_id,
    input  logic [8:0]          bin_index,
    output logic [2:0]          status,
    output logic [3:0]          range_mask,
    output logic [31:0]         count_x,
    output logic [31:0]         count_y,
    output logic [31:0]         count_z,
    output logic [31:0]         count_speed
);

    localparam int NBINS = BIN_SPAN + 1;
    localparam int AW    = $clog2(NBINS);

    // configuration
    logic signed [31:0] beta_reg;
    logic [30:0]        igam_reg;
    logic [3:0]         spec_reg;
    logic [15:0]        cell_lo_reg;
    logic [15:0]        cell_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg    <= '0;
            igam_reg    <= 31'h4000_0000;
            spec_reg    <= '0;
            cell_lo_reg <= '0;
            cell_hi_reg <= 16'hffff;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bvh_pkg::REG_BETA:      beta_reg    <= cfg_data;
                bvh_pkg::REG_INV_GAMMA: igam_reg    <= cfg_data[30:0];
                bvh_pkg::REG_SPECIES:   spec_reg    <= cfg_data[3:0];
                bvh_pkg::REG_CELL_LO:   cell_lo_reg <= cfg_data[15:0];
                bvh_pkg::REG_CELL_HI:   cell_hi_reg <= cfg_data[15:0];
                default:                ;
            endcase
        end
    end

    assign stat.keep = (func == bvh_pkg::FUNC_ADD) && (species_id == spec_reg)
                       && (cell_number >= cell_lo_reg) && (cell_number < cell_hi_reg);

    // captured item
    logic signed [31:0] ux_reg, uy_reg, uz_reg;
    logic [30:0]        ig_reg;
    logic               oor_reg;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [65:0] rnd24, rnd30;

    logic signed [31:0] vx0_reg, vy0_reg, vz0_reg;
    logic [33:0]        d_reg;
    logic signed [34:0] d_raw;
    logic signed [33:0] num_reg [3];

    // divider lanes
    logic [33:0] mag_reg [3];
    logic        neg_reg [3];
    logic        ovf_reg [3];
    logic [33:0] rem_reg [3];
    logic [31:0] q_reg   [3];
    logic signed [31:0] v_reg [3];
    logic [4:0]  it_reg;

    // square root
    logic [63:0] sum_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [63:0] sq_try;
    logic signed [31:0] sp;

    // bins
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] baddr_reg [4];
    logic          bok_reg   [4];
    logic signed [31:0] bin_v [4];
    logic [31:0]   rd_reg    [4];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            bvh_pkg::OP_MUL_VX0:
            begin
                mul_a = {ux_reg[31], ux_reg};
                mul_b = {2'b00, ig_reg};
            end
            bvh_pkg::OP_MUL_VY0:
            begin
                mul_a = {uy_reg[31], uy_reg};
                mul_b = {2'b00, ig_reg};
            end
            bvh_pkg::OP_MUL_VZ0:
            begin
                mul_a = {uz_reg[31], uz_reg};
                mul_b = {2'b00, ig_reg};
            end
            bvh_pkg::OP_MUL_D:
            begin
                mul_a = {vy0_reg[31], vy0_reg};
                mul_b = {beta_reg[31], beta_reg};
            end
            bvh_pkg::OP_MUL_NX:
            begin
                mul_a = {2'b00, igam_reg};
                mul_b = {vx0_reg[31], vx0_reg};
            end
            bvh_pkg::OP_MUL_NZ:
            begin
                mul_a = {2'b00, igam_reg};
                mul_b = {vz0_reg[31], vz0_reg};
            end
            bvh_pkg::OP_SQ_X:
            begin
                mul_a = {v_reg[0][31], v_reg[0]};
                mul_b = {v_reg[0][31], v_reg[0]};
            end
            bvh_pkg::OP_SQ_Y:
            begin
                mul_a = {v_reg[1][31], v_reg[1]};
                mul_b = {v_reg[1][31], v_reg[1]};
            end
            bvh_pkg::OP_SQ_Z:
            begin
                mul_a = {v_reg[2][31], v_reg[2]};
                mul_b = {v_reg[2][31], v_reg[2]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rnd24  = (prod_reg + (66'sd1 <<< 23)) >>> 24;
    assign rnd30  = (prod_reg + (66'sd1 <<< 29)) >>> 30;
    assign d_raw  = 35'sd1073741824 + rnd30[34:0];
    assign sq_try = r_reg + bit_reg;
    assign sp     = (r_reg >= 64'h8000_0000) ? 32'sh7fffffff : $signed(r_reg[31:0]);

    assign bin_v[0] = v_reg[0];
    assign bin_v[1] = v_reg[1];
    assign bin_v[2] = v_reg[2];
    assign bin_v[3] = sp;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            bvh_pkg::OP_ACCEPT:
            begin
                ux_reg  <= mom_x;
                uy_reg  <= mom_y;
                uz_reg  <= mom_z;
                ig_reg  <= inv_lorentz;
                oor_reg <= ({23'b0, bin_index} > 32'(BIN_SPAN));
            end
            bvh_pkg::OP_MUL_VY0: vx0_reg <= bvh_pkg::sat32(rnd24);
            bvh_pkg::OP_MUL_VZ0: vy0_reg <= bvh_pkg::sat32(rnd24);
            bvh_pkg::OP_MUL_D:   vz0_reg <= bvh_pkg::sat32(rnd24);
            bvh_pkg::OP_MUL_NX:
            begin
                if (d_raw <= 35'sd0)
                    d_reg <= 34'd1;
                else
                    d_reg <= d_raw[33:0];
            end
            bvh_pkg::OP_MUL_NZ:
            begin
                num_reg[0] <= rnd30[33:0];
                num_reg[1] <= 34'(vy0_reg) + 34'(beta_reg);
            end
            bvh_pkg::OP_NUM_Z:   num_reg[2] <= rnd30[33:0];
            bvh_pkg::OP_SQ_Y:    sum_reg <= prod_reg[63:0];
            bvh_pkg::OP_SQ_Z:    sum_reg <= sum_reg + prod_reg[63:0];
            bvh_pkg::OP_SQ_ACC:
            begin
                sum_reg <= sum_reg + prod_reg[63:0];
                r_reg   <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            bvh_pkg::OP_SQRT_STEP:
            begin
                if (sum_reg >= sq_try)
                begin
                    sum_reg <= sum_reg - sq_try;
                    r_reg   <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default: ;
        endcase
    end

    // divider lanes: quotient of |num| * 2^30 by d, one bit per step
    for (genvar l = 0; l < 3; l++)
    begin : g_div
        logic [33:0] mag;
        logic        dbit;
        logic [34:0] rem_sh;
        logic        ge;

        assign mag    = num_reg[l][33] ? 34'(-num_reg[l]) : num_reg[l];
        assign dbit   = (it_reg == 5'd31) ? mag_reg[l][1] :
                        (it_reg == 5'd30) ? mag_reg[l][0] : 1'b0;
        assign rem_sh = {rem_reg[l], dbit};
        assign ge     = (rem_sh >= {1'b0, d_reg});

        always_ff @(posedge clk)
        begin
            case (cmd.op)
                bvh_pkg::OP_DIV_INIT:
                begin
                    mag_reg[l] <= mag;
                    neg_reg[l] <= num_reg[l][33];
                    ovf_reg[l] <= ({2'b00, mag} >= {d_reg, 2'b00});
                    rem_reg[l] <= mag >> 2;
                    q_reg[l]   <= '0;
                end
                bvh_pkg::OP_DIV_STEP:
                begin
                    if (ge)
                        rem_reg[l] <= 34'(rem_sh - {1'b0, d_reg});
                    else
                        rem_reg[l] <= rem_sh[33:0];
                    q_reg[l] <= {q_reg[l][30:0], ge};
                end
                bvh_pkg::OP_DIV_FIN:
                begin
                    if (ovf_reg[l])
                        v_reg[l] <= neg_reg[l] ? 32'sh80000000 : 32'sh7fffffff;
                    else if (neg_reg[l])
                        v_reg[l] <= (q_reg[l] > 32'h8000_0000) ? 32'sh80000000
                                                               : $signed(-q_reg[l]);
                    else
                        v_reg[l] <= (q_reg[l] >= 32'h8000_0000) ? 32'sh7fffffff
                                                                : $signed(q_reg[l]);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg       <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.op == bvh_pkg::OP_DIV_INIT || cmd.op == bvh_pkg::OP_SQ_ACC)
                it_reg <= 5'd31;
            else if (cmd.op == bvh_pkg::OP_DIV_STEP || cmd.op == bvh_pkg::OP_SQRT_STEP)
                it_reg <= it_reg - 5'd1;
            if (cmd.op == bvh_pkg::OP_CLR)
                clr_addr_reg <= stat.clr_last ? '0 : clr_addr_reg + 1'b1;
        end
    end

    assign stat.it_last  = (it_reg == 5'd0);
    assign stat.clr_last = (clr_addr_reg == AW'(BIN_SPAN));

    // bin mapping and histogram memories
    for (genvar h = 0; h < 4; h++)
    begin : g_hist
        logic [31:0]        mem [NBINS];
        logic signed [47:0] bp;
        logic signed [16:0] bin;
        logic [AW-1:0]      raddr;

        assign bp    = 48'(BIN_SPAN) * (48'sd1073741824 + 48'(bin_v[h]))
                       + 48'sd1073741824;
        assign bin   = bp[47:31];
        assign raddr = (cmd.op == bvh_pkg::OP_ACCEPT) ? AW'(bin_index) : baddr_reg[h];

        always_ff @(posedge clk)
        begin
            if (cmd.op == bvh_pkg::OP_BIN)
            begin
                baddr_reg[h] <= bin[AW-1:0];
                bok_reg[h]   <= (bin >= 17'sd0) && (bin <= 17'(BIN_SPAN));
            end
            if (cmd.op == bvh_pkg::OP_ACCEPT || cmd.op == bvh_pkg::OP_RMW_RD)
                rd_reg[h] <= mem[raddr];
            if (cmd.op == bvh_pkg::OP_CLR)
                mem[clr_addr_reg] <= '0;
            else if (cmd.op == bvh_pkg::OP_RMW_WR && bok_reg[h])
                mem[baddr_reg[h]] <= (rd_reg[h] == 32'hffff_ffff) ? rd_reg[h]
                                                                   : rd_reg[h] + 32'd1;
        end
    end

    // result registers
    logic [2:0]  status_reg;
    logic [3:0]  mask_reg;
    logic [31:0] cnt_reg [4];
    logic [3:0]  miss;

    assign miss = {~bok_reg[3], ~bok_reg[2], ~bok_reg[1], ~bok_reg[0]};

    always_ff @(posedge clk)
    begin
        if (cmd.res_en)
        begin
            mask_reg <= '0;
            for (int k = 0; k < 4; k++)
                cnt_reg[k] <= '0;
            case (cmd.op)
                bvh_pkg::OP_CLR:  status_reg <= bvh_pkg::ST_CLEARED;
                bvh_pkg::OP_RDOUT:
                begin
                    status_reg <= bvh_pkg::ST_READ;
                    if (oor_reg)
                        mask_reg <= 4'hf;
                    else
                        for (int k = 0; k < 4; k++)
                            cnt_reg[k] <= rd_reg[k];
                end
                bvh_pkg::OP_RMW_WR:
                begin
                    status_reg <= (miss != 4'h0) ? bvh_pkg::ST_OOR : bvh_pkg::ST_COUNTED;
                    mask_reg   <= miss;
                end
                default: status_reg <= bvh_pkg::ST_FILTERED;
            endcase
        end
    end

    assign status      = status_reg;
    assign range_mask  = mask_reg;
    assign count_x     = cnt_reg[0];
    assign count_y     = cnt_reg[1];
    assign count_z     = cnt_reg[2];
    assign count_speed = cnt_reg[3];

endmodule

FILE: rtl/boosted_velocity_histogram.sv
// top level of the boosted velocity histogram: controller plus datapath
// depends on bvh_pkg, bvh_ctrl, bvh_datapath and the defines header
//
//  channel   handshake          payload
//  input     start, busy        func, mom_x/y/z, inv_lorentz, cell_number, species_id, bin_index
//  result    done (one cycle)   status, range_mask, count_x/y/z, count_speed
//  config    cfg_we             cfg_index, cfg_data
//
// a particle runs 32 divider steps and 32 square-root steps; every product uses one shared multiplier
// a clear zeroes one bin per cycle, from bin 0 up to BIN_SPAN
// after reset a clearing pass over every bin runs with busy high
// one transaction at a time; done is never held off by the receiver
`include "boosted_velocity_histogram_defines.svh"
module boosted_velocity_histogram
#(
    parameter int BIN_SPAN = bvh_pkg::BIN_SPAN_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic signed [31:0] mom_x,
    input  logic signed [31:0] mom_y,
    input  logic signed [31:0] mom_z,
    input  logic [30:0]        inv_lorentz,
    input  logic [15:0]        cell_number,
    input  logic [3:0]         species_id,
    input  logic [8:0]         bin_index,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic [2:0]         status,
    output logic [3:0]         range_mask,
    output logic [31:0]        count_x,
    output logic [31:0]        count_y,
    output logic [31:0]        count_z,
    output logic [31:0]        count_speed
);

    bvh_pkg::bvh_cmd_t  cmd;
    bvh_pkg::bvh_stat_t stat;

    bvh_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bvh_datapath #(
        .BIN_SPAN (BIN_SPAN)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .mom_x       (mom_x),
        .mom_y       (mom_y),
        .mom_z       (mom_z),
        .inv_lorentz (inv_lorentz),
        .cell_number (cell_number),
        .species_id  (species_id),
        .bin_index   (bin_index),
        .status      (status),
        .range_mask  (range_mask),
        .count_x     (count_x),
        .count_y     (count_y),
        .count_z     (count_z),
        .count_speed (count_speed)
    );

    `BVH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `BVH_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
    `BVH_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `BVH_ASSERT_NOW(a_mask_status, done && status == bvh_pkg::ST_COUNTED, range_mask == 4'h0, "mask set")

endmodule
